### hdl/pd_pkg.sv
`default_nettype none

package pd_pkg;

    localparam int unsigned MaxResults = 3;
    localparam int unsigned QueueDepth = 4;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PERCENT = 2'd1,
        PH_DIGIT   = 2'd2
    } t_phase;

    // Results of one input transaction, handed from decoder to output queue.
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  item2;
        t_out_item  item1;
        t_out_item  item0;
    } t_push;

    // Bit 4 set: character is a hex digit; bits 3:0 hold its value.
    function automatic logic [4:0] hex_val(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= CH_ZERO && ch <= CH_ZERO + 8'd9) begin
            r = {1'b1, 4'(ch - CH_ZERO)};
        end else if (ch >= CH_LOW_A && ch <= CH_LOW_A + 8'd5) begin
            r = {1'b1, 4'(ch - CH_LOW_A + 8'd10)};
        end else if (ch >= CH_UP_A && ch <= CH_UP_A + 8'd5) begin
            r = {1'b1, 4'(ch - CH_UP_A + 8'd10)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/pd_decode.sv
`default_nettype none

module pd_decode
    import pd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output t_push         o_push
);

    logic       r_form_mode;
    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;

    logic [7:0] ch;
    logic [4:0] cur_hex;
    logic [4:0] held_hex;
    logic       fresh;
    logic [1:0] n;
    t_out_item  res [MaxResults];

    always_comb begin
        ch = i_item.in_byte;
        if (r_form_mode && ch == CH_PLUS) begin
            ch = CH_SPACE;
        end
        cur_hex  = hex_val(ch);
        held_hex = hex_val(r_held);
        n        = 2'd0;
        fresh    = 1'b0;
        n_phase  = r_phase;
        n_held   = r_held;
        for (int k = 0; k < MaxResults; k++) begin
            res[k] = '{out_byte: 8'd0, out_last: 1'b0};
        end

        unique case (r_phase)
            PH_PERCENT: begin
                if (cur_hex[4]) begin
                    if (i_item.in_last) begin
                        res[0].out_byte = CH_PERCENT;
                        res[1].out_byte = ch;
                        n               = 2'd2;
                        n_phase         = PH_IDLE;
                    end else begin
                        n_held  = ch;
                        n_phase = PH_DIGIT;
                    end
                end else begin
                    res[0].out_byte = CH_PERCENT;
                    n               = 2'd1;
                    fresh           = 1'b1;
                end
            end
            PH_DIGIT: begin
                if (cur_hex[4]) begin
                    res[0].out_byte = {held_hex[3:0], cur_hex[3:0]};
                    n               = 2'd1;
                    n_phase         = PH_IDLE;
                end else begin
                    res[0].out_byte = CH_PERCENT;
                    res[1].out_byte = r_held;
                    n               = 2'd2;
                    fresh           = 1'b1;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase

        if (fresh) begin
            if (ch == CH_PERCENT && !i_item.in_last) begin
                n_phase = PH_PERCENT;
            end else begin
                res[n].out_byte = ch;
                n               = n + 2'd1;
                n_phase         = PH_IDLE;
            end
        end

        if (i_item.in_last) begin
            n_phase = PH_IDLE;
            if (n != 2'd0) begin
                res[n - 2'd1].out_last = 1'b1;
            end
        end

        o_push.cnt   = i_accept ? n : 2'd0;
        o_push.item0 = res[0];
        o_push.item1 = res[1];
        o_push.item2 = res[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_form_mode <= 1'b0;
            r_phase     <= PH_IDLE;
            r_held      <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_form_mode <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_held  <= n_held;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/pd_outq.sv
`default_nettype none

module pd_outq
    import pd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_out_item  o_item
);

    localparam int unsigned CntW = $clog2(QueueDepth + 1);
    localparam int unsigned IdxW = $clog2(QueueDepth);

    t_out_item       r_q [QueueDepth];
    t_out_item       n_q [QueueDepth];
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [CntW-1:0] base;
    logic [CntW-1:0] idx;
    logic            pop;
    t_out_item       push_item [MaxResults];

    always_comb begin
        push_item[0] = i_push.item0;
        push_item[1] = i_push.item1;
        push_item[2] = i_push.item2;
        pop  = (r_cnt != '0) && i_ready;
        base = r_cnt - CntW'(pop);
        // shift down on pop, head stays at slot 0
        for (int k = 0; k < QueueDepth; k++) begin
            if (pop && k < QueueDepth - 1) begin
                n_q[k] = r_q[k + 1];
            end else begin
                n_q[k] = r_q[k];
            end
        end
        // append new results behind what remains
        for (int j = 0; j < MaxResults; j++) begin
            idx = base + CntW'(j);
            if (CntW'(j) < CntW'(i_push.cnt)) begin
                n_q[idx[IdxW-1:0]] = push_item[j];
            end
        end
        n_cnt = base + CntW'(i_push.cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    // Room for a full burst of results regardless of the output side.
    assign o_room  = r_cnt <= CntW'(QueueDepth - MaxResults);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_q[0];

endmodule

`default_nettype wire

### hdl/percent_decoder.sv
`default_nettype none

// Streaming URL percent-escape decoder. Encoded characters enter one per input
// transaction on the in channel (in_last marks the end of a string); decoded
// characters leave one per transaction on the out channel, out_last set on the
// final decoded character. '%' plus two hex digits of either case becomes one
// byte; a broken or truncated escape passes through literally and the breaking
// character is reconsidered, so it may open a new escape. With form_mode set
// (i_cfg_we / i_cfg_wdata, write only while idle), '+' becomes a space first.
// Timing: an input transaction is decoded in the cycle it is accepted and its
// zero to three results are registered into the output queue behind those it
// holds, leaving at one per cycle while i_out_ready is high. The four-entry
// queue accepts input whenever it holds at most one result, so with out ready a
// one-result-per-character stream runs at one character per cycle; characters
// flushing 2 or 3 literal bytes take longer, set by the single output port.
module percent_decoder
    import pd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_item
);

    t_push push;
    logic  room;
    logic  accept;

    // Accept only when the queue can absorb the largest burst of results.
    assign o_in_ready = room;
    assign accept     = i_in_valid && room;

    // Escape tracking, form mode and the per-character result list.
    pd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_push      (push)
    );

    // Hold results and advance them one per output transaction.
    pd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

### hdl/pd_checker.sv
`default_nettype none

module pd_checker
    import pd_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in_item,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // A stalled result holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output transaction dropped or changed while stalled");

    // Backpressure on input only comes from results waiting on the output.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending output");

    // The end of a string always produces at least one result.
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.in_last |=> o_out_valid)
        else $error("final character produced no output");

endmodule

bind percent_decoder pd_checker u_pd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire
